/* hw/rtl/i2cee_pkg.sv */
// ============================================================================
// i2cee_pkg: shared types and constants for the serial EEPROM slave
// Protocol states, device select codes and the queue word between front/back.
// ============================================================================
`default_nettype none
package i2cee_pkg;

    typedef enum logic [2:0] {
        PS_IDLE = 3'd0,
        PS_RECV = 3'd1,
        PS_ACK  = 3'd2,
        PS_SEND = 3'd3,
        PS_WACK = 3'd4
    } t_proto;

    typedef enum logic [1:0] {
        BK_RUN    = 2'd0,
        BK_COMMIT = 2'd1,
        BK_RDWAIT = 2'd2
    } t_back_state;

    localparam logic [9:0] DEV_WRITE = 10'h1A0;
    localparam logic [9:0] DEV_READ  = 10'h1A1;
    localparam logic [7:0] DEV_SEL   = 8'hA0;
    localparam logic [7:0] ERASED    = 8'hFF;

    localparam logic ADDR_SMALL = 1'b0;
    localparam logic ADDR_BUSY  = 1'b1;

    // one pin update, as it travels from the front to the back
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic [31:0] now;
    } t_pin_word;

endpackage
`default_nettype wire

/* hw/rtl/i2cee_front.sv */
// ============================================================================
// i2cee_front: pin update intake and two-entry queue
// Accepts pin updates and holds them until the protocol engine takes them.
// ============================================================================
`default_nettype none
module i2cee_front
    import i2cee_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_pin_word i_word,
    output logic           o_valid,
    input  wire logic      i_take,
    output t_pin_word      o_word
);

    t_pin_word  r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_take;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_ready) else $error("full queue accepts");
    a_pop_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push && r_cnt == 2'd1) |=> !o_valid)
        else $error("queue count slip");

endmodule
`default_nettype wire

/* hw/rtl/i2cee_back.sv */
// ============================================================================
// i2cee_back: protocol engine, packet buffer, EEPROM array and commit
// Runs the pin model for one update; page commit writes one byte per cycle.
// ============================================================================
`default_nettype none
module i2cee_back
    import i2cee_pkg::*;
#(
    parameter int MEM_BYTES    = 32768,
    parameter int PAGE_BYTES   = 64,
    parameter int PACKET_BYTES = 70
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_small_mode,
    input  wire logic [15:0] i_busy_cycles,
    input  wire logic      i_valid,
    output logic           o_take,
    input  wire t_pin_word i_word,
    output logic           o_res_valid,
    input  wire logic      i_res_ready,
    output logic [2:0]     o_res,
    output logic           o_clearing
);
    localparam int MA = $clog2(MEM_BYTES);
    localparam int PA = $clog2(PAGE_BYTES);
    localparam int PB = $clog2(PACKET_BYTES + 1);
    localparam int BA = $clog2(PACKET_BYTES);

    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_pkt [PACKET_BYTES];
    logic [PB-1:0] r_pcnt;
    logic [9:0]  r_shift;
    t_proto      r_ps;
    logic [15:0] r_addr;
    logic [7:0]  r_pb1, r_pb2;
    logic        r_chip, r_lscl, r_lsda, r_trun;
    logic [31:0] r_tstart;
    t_back_state r_bs, n_bs;
    logic        r_clr;
    logic [MA-1:0] r_clr_a;
    logic [PB-1:0] r_ci, r_cend;
    logic [7:0]  r_rd;
    logic        r_rdok;
    logic        r_ovf;
    logic [2:0]  r_res;
    logic        r_rv;
    logic        w_go;

    // packet buffer read data, registered, feeds the commit writes
    logic [7:0]    r_pd;
    logic [BA-1:0] w_pd_idx;

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr[MA-1:0]];
    end

    // memory write: clearing sweep or commit
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_a] <= ERASED;
        end else if (r_bs == BK_COMMIT && r_ci < r_cend) begin
            r_mem[r_addr[MA-1:0]] <= r_pd;
        end
    end

    // combinational step model
    logic        s_fall, s_start, s_stop, s_need_rd;
    logic [9:0]  n_shift;
    t_proto      n_ps;
    logic [15:0] n_addr;
    logic [PB-1:0] n_pcnt;
    logic        n_chip, n_commit, n_trun;
    logic [7:0]  n_pb1, n_pb2;
    logic        wr_pkt;
    logic [BA-1:0] wr_idx;
    logic [7:0]  wr_dat;
    logic [PB-1:0] n_cend;
    logic [31:0] w_el;
    logic [9:0]  t_sh;
    logic        t_chip;

    always_comb begin
        n_shift = r_shift; n_ps = r_ps; n_addr = r_addr; n_pcnt = r_pcnt;
        n_chip = r_chip; n_commit = 1'b0; n_trun = r_trun;
        n_pb1 = r_pb1; n_pb2 = r_pb2; wr_pkt = 1'b0; wr_idx = '0; wr_dat = '0;
        n_cend = r_pcnt;
        s_need_rd = 1'b0; t_sh = '0; t_chip = 1'b0;
        w_el = i_word.now - r_tstart;
        s_fall = !i_word.scl && r_lscl;
        if (s_fall) begin
            unique case (r_ps)
                PS_RECV: begin
                    n_shift = {r_shift[8:0], r_lsda};
                    if (n_shift[8]) begin
                        if (r_pcnt == '0) begin
                            wr_pkt = 1'b1; wr_idx = '0; wr_dat = n_shift[7:0];
                            if (i_small_mode && n_shift[7:4] == DEV_SEL[7:4]) begin
                                n_pb1 = {5'd0, n_shift[3:1]};
                                n_shift = n_shift & DEV_READ;
                            end
                            if (n_shift == DEV_WRITE) begin
                                n_ps = PS_ACK; n_chip = 1'b0;
                            end else if (n_shift == DEV_READ) begin
                                n_ps = PS_WACK; n_chip = 1'b0;
                            end else n_ps = PS_IDLE;
                        end else begin
                            n_ps = PS_ACK; n_chip = 1'b0;
                        end
                    end
                end
                PS_ACK: begin
                    if (r_shift != '0) begin
                        if (r_pcnt == '0) begin
                            n_pcnt = i_small_mode ? PB'(2) : PB'(1);
                        end else if (r_pcnt < PB'(PACKET_BYTES)) begin
                            wr_pkt = 1'b1; wr_idx = r_pcnt[BA-1:0];
                            wr_dat = r_shift[7:0];
                            if (r_pcnt == PB'(1)) n_pb1 = r_shift[7:0];
                            if (r_pcnt == PB'(2)) n_pb2 = r_shift[7:0];
                            n_pcnt = r_pcnt + PB'(1);
                            n_addr = {(r_pcnt == PB'(1)) ? r_shift[7:0] : r_pb1,
                                      (r_pcnt == PB'(2)) ? r_shift[7:0] : r_pb2};
                        end
                    end
                    n_chip = 1'b1; n_shift = 10'd1; n_ps = PS_RECV;
                end
                PS_SEND, PS_WACK: begin
                    t_sh = r_shift; t_chip = r_chip;
                    if (r_ps == PS_WACK && r_lsda && r_chip) begin
                        n_ps = PS_IDLE;
                    end else begin
                        if (r_ps == PS_WACK) begin
                            s_need_rd = 1'b1;
                            t_sh = {1'b0, r_rd, 1'b1};
                        end
                        n_ps = PS_SEND;
                        n_chip = t_sh[8];
                        n_shift = {t_sh[8:0], 1'b0};
                        if (n_shift[8:1] == '0) begin
                            n_ps = PS_WACK; n_chip = 1'b1;
                            n_addr = r_addr + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
        // data edges judged with the new chip level
        s_start = !i_word.sda && r_lsda && n_chip && i_word.scl;
        s_stop  = i_word.sda && !r_lsda && n_chip && i_word.scl;
        if (s_start) begin
            if (r_trun) n_trun = (w_el < {16'd0, i_busy_cycles});
            n_ps = (r_trun && (w_el < {16'd0, i_busy_cycles})) ? PS_IDLE : PS_ACK;
            n_pcnt = '0; n_shift = '0;
            wr_pkt = 1'b1; wr_idx = '0; wr_dat = '0;
        end else if (s_stop) begin
            if (n_ps == PS_RECV && n_shift == 10'd1 && n_pcnt > PB'(3)) begin
                n_commit = 1'b1; n_trun = 1'b1;
                if ((((n_addr + 16'(n_pcnt) - 16'd4) ^ n_addr) >> PA) != '0)
                    n_cend = PB'(4 + (PAGE_BYTES - 1) - int'(n_addr[PA-1:0]));
                else n_cend = n_pcnt;
            end
            n_ps = PS_IDLE;
        end
    end

    // back control: step, read wait, commit loop
    always_comb begin
        n_bs = r_bs;
        unique case (r_bs)
            BK_RUN: if (i_valid && !r_clr && !(r_rv && !i_res_ready)) begin
                if (s_need_rd && !r_rdok) n_bs = BK_RDWAIT;
                else if (n_commit) n_bs = BK_COMMIT;
            end
            BK_RDWAIT: n_bs = BK_RUN;
            BK_COMMIT: if (r_ci >= r_cend || r_ovf) n_bs = BK_RUN;
            default: n_bs = BK_RUN;
        endcase
    end

    assign w_go = (r_bs == BK_RUN) && i_valid && !r_clr && !(r_rv && !i_res_ready)
                  && !(s_need_rd && !r_rdok);
    assign o_take = w_go;
    assign o_res_valid = r_rv;
    assign o_res = r_res;
    assign o_clearing = r_clr;

    // next packet byte to present to the commit loop
    always_comb begin
        if (w_go) w_pd_idx = BA'(3);
        else if (r_bs == BK_COMMIT && r_ci < r_cend && !r_ovf)
            w_pd_idx = r_ci[BA-1:0] + BA'(1);
        else w_pd_idx = r_ci[BA-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_pkt && w_go) r_pkt[wr_idx] <= wr_dat;
        r_pd <= r_pkt[w_pd_idx];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= BK_RUN; r_clr <= 1'b1; r_clr_a <= '0;
            r_pcnt <= '0; r_shift <= '0; r_ps <= PS_IDLE; r_addr <= '0;
            r_pb1 <= '0; r_pb2 <= '0; r_chip <= 1'b1; r_lscl <= 1'b0;
            r_lsda <= 1'b0; r_trun <= 1'b0; r_tstart <= '0; r_rv <= 1'b0;
            r_ci <= '0; r_cend <= '0; r_ovf <= 1'b0; r_rdok <= 1'b0;
        end else begin
            r_bs <= n_bs;
            r_rdok <= (r_bs == BK_RDWAIT);
            if (r_clr) begin
                r_clr_a <= r_clr_a + MA'(1);
                if (r_clr_a == MA'(MEM_BYTES - 1)) r_clr <= 1'b0;
            end
            r_rv <= w_go || (r_rv && !i_res_ready);
            if (w_go) begin
                r_shift <= n_shift; r_ps <= n_ps; r_addr <= n_addr;
                r_pcnt <= n_pcnt; r_chip <= n_chip; r_trun <= n_trun;
                r_pb1 <= n_pb1; r_pb2 <= n_pb2;
                r_lscl <= i_word.scl; r_lsda <= i_word.sda;
                if (n_commit) r_tstart <= i_word.now;
                r_ci <= PB'(3); r_cend <= n_cend; r_ovf <= 1'b0;
                r_res <= {n_trun, n_ps != PS_IDLE, i_word.sda && n_chip};
            end
            if (r_bs == BK_COMMIT && r_ci < r_cend && !r_ovf) begin
                r_addr <= r_addr + 16'd1;
                r_ci <= r_ci + PB'(1);
                if (r_ci == PB'(PACKET_BYTES - 1) ||
                    (r_addr[PA-1:0] + PA'(1)) == '0) r_ovf <= 1'b1;
            end
        end
    end

    a_one_activity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr && r_bs == BK_COMMIT)) else $error("commit during clearing");
    a_commit_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs == BK_COMMIT) |-> !o_take) else $error("take during commit");
    a_rdwait_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs == BK_RDWAIT) |=> (r_bs == BK_RUN)) else $error("read wait stuck");

endmodule
`default_nettype wire

/* hw/rtl/i2c_serial_eeprom_slave.sv */
// ============================================================================
// i2c_serial_eeprom_slave: pin-level serial EEPROM slave
// Top level: APB registers, pin-word intake queue and protocol engine.
// ============================================================================
// Usage: each s_axis word is one SCL/SDA pin update with a cycle stamp;
// each update yields exactly one m_axis word with the wired-and SDA level,
// bus activity and write-busy flag after that update.
// Each update passes through the queue and the engine's result register; an
// update that starts a read byte first waits in a read-wait state for the array read.
// A STOP that commits a page writes one byte per cycle, up to the page size,
// so such an update holds the engine until the page commit is done.
// After reset the array is erased to 0xFF by a sweep over every address,
// during which updates queue but are not processed; registers are writable.
// When m_axis_tready is low the finished word waits in the output register;
// the queue absorbs two more updates, then s_axis_tready drops.
// Registers: 0x0 small_mode (bit 0), 0x4 write_busy_cycles (bits 15:0).
// ============================================================================
`default_nettype none
module i2c_serial_eeprom_slave
    import i2cee_pkg::*;
#(
    parameter int MEM_BYTES    = 32768,
    parameter int PAGE_BYTES   = 64,
    parameter int PACKET_BYTES = 70
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] scl_level, [1] sda_level, [33:2] now_cycles, [39:34] zero
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] sda_read, [1] bus_active, [2] write_busy, [7:3] zero
    output logic [7:0]       m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic        r_small;
    logic [15:0] r_busy;
    t_pin_word   w_in, w_q;
    logic        w_qv, w_take, w_clr;
    logic [2:0]  w_res;

    assign pready = 1'b1;
    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small <= 1'b0;
            r_busy  <= 16'd5966;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_SMALL) r_small <= pwdata[0];
            else                        r_busy  <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == ADDR_BUSY) ? {16'd0, r_busy} : {31'd0, r_small};

    assign w_in = '{scl: s_axis_tdata[0], sda: s_axis_tdata[1], now: s_axis_tdata[33:2]};

    i2cee_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (s_axis_tvalid), .o_ready (s_axis_tready), .i_word (w_in),
        .o_valid (w_qv), .i_take (w_take), .o_word (w_q)
    );

    i2cee_back #(.MEM_BYTES(MEM_BYTES), .PAGE_BYTES(PAGE_BYTES),
                 .PACKET_BYTES(PACKET_BYTES)) u_back (
        .i_clk, .i_rst_n,
        .i_small_mode (r_small), .i_busy_cycles (r_busy),
        .i_valid (w_qv), .o_take (w_take), .i_word (w_q),
        .o_res_valid (m_axis_tvalid), .i_res_ready (m_axis_tready),
        .o_res (w_res), .o_clearing (w_clr)
    );
    assign m_axis_tdata = {5'd0, w_res};

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr |-> !w_take) else $error("item processed during erase");
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0)) else $error("pad bits");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_qv) else $error("take from empty queue");

endmodule
`default_nettype wire

/* bench/i2c_serial_eeprom_checker.sv */
// ----------------------------------------------------------------------------
// i2c_serial_eeprom_checker: scoreboard for the serial EEPROM slave
// Mirrors the pin-level protocol engine and memory array, computes the
// status word due for every accepted pin update and compares it, in order,
// with the words the block returns. Register writes are tracked off the bus.
// ----------------------------------------------------------------------------
module i2c_serial_eeprom_checker
    import i2cee_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    // [0] scl_level, [1] sda_level, [33:2] now_cycles, [39:34] zero
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] sda_read, [1] bus_active, [2] write_busy, [7:3] zero
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_SIZE  = 32768;
    localparam int PKT_SIZE  = 70;
    localparam int PAGE_SIZE = 64;
    localparam logic [2:0] REG_SMALL = 3'h0;
    localparam logic [2:0] REG_BUSY  = 3'h4;

    // mirrored chip state
    logic [7:0]  mem_img [MEM_SIZE];
    logic [7:0]  pkt_buf [PKT_SIZE];
    int unsigned pkt_cnt;
    logic [9:0]  shreg;
    t_proto      pstate;
    logic [15:0] addr_ptr;
    logic        chip_drv;
    logic        prev_scl;
    logic        prev_sda;
    logic        busy_flag;
    logic [31:0] busy_t0;
    logic        small_cfg;
    logic [15:0] busy_len;

    logic [7:0]  status_q [$];

    assign o_pending = status_q.size();

    // falling SCL: shift, acknowledge or send
    task automatic scl_fall();
        case (pstate)
            PS_RECV: begin
                shreg = {shreg[8:0], prev_sda};
                if (shreg[8]) begin
                    if (pkt_cnt == 0) begin
                        pkt_buf[0] = shreg[7:0];
                        if (small_cfg && shreg[7:4] == DEV_SEL[7:4]) begin
                            pkt_buf[1] = {5'd0, shreg[3:1]};
                            shreg = shreg & DEV_READ;
                        end
                        if (shreg == DEV_WRITE) begin
                            pstate = PS_ACK;
                            chip_drv = 1'b0;
                        end else if (shreg == DEV_READ) begin
                            pstate = PS_WACK;
                            chip_drv = 1'b0;
                        end else begin
                            pstate = PS_IDLE;
                        end
                    end else begin
                        pstate = PS_ACK;
                        chip_drv = 1'b0;
                    end
                end
            end
            PS_ACK: begin
                if (shreg != 0) begin
                    if (pkt_cnt == 0) begin
                        pkt_buf[0] = shreg[7:0];
                        pkt_cnt = small_cfg ? 2 : 1;
                    end else if (pkt_cnt < PKT_SIZE) begin
                        pkt_buf[pkt_cnt] = shreg[7:0];
                        pkt_cnt++;
                        addr_ptr = {pkt_buf[1], pkt_buf[2]};
                    end
                end
                chip_drv = 1'b1;
                shreg = 10'd1;
                pstate = PS_RECV;
            end
            PS_SEND, PS_WACK: begin
                if (pstate == PS_WACK && prev_sda && chip_drv) begin
                    pstate = PS_IDLE;
                end else begin
                    if (pstate == PS_WACK) begin
                        pstate = PS_SEND;
                        shreg = {1'b0, mem_img[addr_ptr[14:0]], 1'b1};
                    end
                    chip_drv = shreg[8];
                    shreg = {shreg[8:0], 1'b0};
                    if (shreg[8:1] == 8'd0) begin
                        pstate = PS_WACK;
                        chip_drv = 1'b1;
                        addr_ptr = addr_ptr + 16'd1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic bus_start(input logic [31:0] now);
        logic [31:0] span;
        span = now - busy_t0;
        if (busy_flag)
            busy_flag = span < {16'd0, busy_len};
        pstate = busy_flag ? PS_IDLE : PS_ACK;
        pkt_cnt = 0;
        shreg = 10'd0;
        pkt_buf[0] = 8'd0;
    endtask

    // STOP after a write commits the buffered bytes, clipped at the page end
    task automatic bus_stop(input logic [31:0] now);
        int unsigned last;
        int unsigned base;
        int unsigned i;
        if (pstate == PS_RECV && shreg == 10'd1 && pkt_cnt > 3) begin
            last = pkt_cnt;
            base = addr_ptr;
            busy_t0 = now;
            busy_flag = 1'b1;
            if (((base + last - 4) ^ base) & ~(PAGE_SIZE - 1))
                last = 4 + (PAGE_SIZE - 1) - (base & (PAGE_SIZE - 1));
            for (i = 3; i < last && i < PKT_SIZE; i++) begin
                mem_img[addr_ptr[14:0]] = pkt_buf[i];
                addr_ptr = addr_ptr + 16'd1;
                if (addr_ptr[5:0] == 6'd0)
                    break;
            end
        end
        pstate = PS_IDLE;
    endtask

    function automatic logic [7:0] status_now();
        return {5'd0, busy_flag, pstate != PS_IDLE, prev_sda & chip_drv};
    endfunction

    task automatic pin_update(input logic scl, input logic sda, input logic [31:0] now);
        if (scl) begin
            prev_scl = 1'b1;
        end else begin
            if (prev_scl)
                scl_fall();
            prev_scl = 1'b0;
        end
        if (sda) begin
            if (!prev_sda && chip_drv && prev_scl)
                bus_stop(now);
            prev_sda = 1'b1;
        end else begin
            if (prev_sda && chip_drv && prev_scl)
                bus_start(now);
            prev_sda = 1'b0;
        end
        status_q.push_back(status_now());
    endtask

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_SIZE; i++)
                mem_img[i] = ERASED;
            for (int i = 0; i < PKT_SIZE; i++)
                pkt_buf[i] = 8'd0;
            o_errors  = 0;
            pkt_cnt   = 0;
            shreg     = 10'd0;
            pstate    = PS_IDLE;
            addr_ptr  = 16'd0;
            chip_drv  = 1'b1;
            prev_scl  = 1'b0;
            prev_sda  = 1'b0;
            busy_flag = 1'b0;
            busy_t0   = 32'd0;
            small_cfg = 1'b0;
            busy_len  = 16'd5966;
            status_q.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr == REG_SMALL)
                    small_cfg = pwdata[0];
                else if (paddr == REG_BUSY)
                    busy_len = pwdata[15:0];
            end
            // result word check
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, m_axis_tdata);
                    o_errors++;
                end else begin
                    want = status_q.pop_front();
                    if (want[0] !== m_axis_tdata[0]) begin
                        $display("%0t: sda_read expected %b actual %b",
                                 $time, want[0], m_axis_tdata[0]);
                        o_errors++;
                    end
                    if (want[1] !== m_axis_tdata[1]) begin
                        $display("%0t: bus_active expected %b actual %b",
                                 $time, want[1], m_axis_tdata[1]);
                        o_errors++;
                    end
                    if (want[2] !== m_axis_tdata[2]) begin
                        $display("%0t: write_busy expected %b actual %b",
                                 $time, want[2], m_axis_tdata[2]);
                        o_errors++;
                    end
                    if (m_axis_tdata[7:3] !== 5'd0) begin
                        $display("%0t: pad bits expected 00 actual %h",
                                 $time, m_axis_tdata[7:3]);
                        o_errors++;
                    end
                end
            end
            // new pin update
            if (s_axis_tvalid && s_axis_tready)
                pin_update(s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[33:2]);
        end
    end

endmodule

/* bench/i2c_serial_eeprom_slave_tb.sv */
// ----------------------------------------------------------------------------
// i2c_serial_eeprom_slave_tb: regression bench for the serial EEPROM slave
// Drives pin updates shaped as I2C transactions (writes, page commits,
// random and current reads, broken frames, raw pin noise) across several
// register settings, with random stalls on both streams. The checker
// module predicts and compares every status word.
// ----------------------------------------------------------------------------
module i2c_serial_eeprom_slave_tb
    import i2cee_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RUN_LIMIT = 3000000;
    localparam int         SETTLE    = 100;
    localparam logic [2:0] REG_SMALL = 3'h0;
    localparam logic [2:0] REG_BUSY  = 3'h4;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          word_cnt;
    logic [31:0] stamp;
    logic        small_on;
    logic        quiet;

    i2c_serial_eeprom_slave DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    i2c_serial_eeprom_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver stalls, none during the quiet stretch
    always @(negedge i_clk)
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);

    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one pin update; called at a falling edge, returns at a falling edge
    task automatic send_pins(input logic scl, input logic sda);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < 40);
        end
        s_axis_tdata  <= {6'd0, stamp, sda, scl};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        word_cnt++;
        if ($urandom_range(0, 99) < 3)
            stamp = stamp + $urandom();
        else
            stamp = stamp + $urandom_range(1, 40);
    endtask

    task automatic bus_start();
        send_pins(1'b0, 1'b1);
        send_pins(1'b1, 1'b1);
        send_pins(1'b1, 1'b0);
    endtask

    task automatic bus_stop();
        send_pins(1'b0, 1'b0);
        send_pins(1'b1, 1'b0);
        send_pins(1'b1, 1'b1);
    endtask

    // eight data bits then the acknowledge clock with SDA released
    task automatic put_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            send_pins(1'b0, b[i]);
            send_pins(1'b1, b[i]);
        end
        send_pins(1'b0, 1'b1);
        send_pins(1'b1, 1'b1);
    endtask

    // read bytes; master acks all but the last
    task automatic get_bytes(input int n);
        logic nak;
        for (int k = 0; k < n; k++) begin
            nak = (k == n - 1);
            for (int i = 0; i < 8; i++) begin
                send_pins(1'b0, 1'b1);
                send_pins(1'b1, 1'b1);
            end
            send_pins(1'b0, nak);
            send_pins(1'b1, nak);
        end
    endtask

    task automatic put_address();
        if (!small_on)
            put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] dev_byte(input logic rd);
        return {DEV_SEL[7:4], small_on ? 3'($urandom_range(0, 7)) : 3'd0, rd};
    endfunction

    task automatic write_frame(input int n);
        bus_start();
        put_byte(dev_byte(1'b0));
        put_address();
        for (int i = 0; i < n; i++)
            put_byte(8'($urandom_range(0, 255)));
        bus_stop();
    endtask

    task automatic random_frame();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            n = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 72) : $urandom_range(0, 6);
            write_frame(n);
            // sometimes probe right away while the write cycle may run
            if ($urandom_range(0, 3) == 0) begin
                bus_start();
                put_byte(dev_byte(1'b0));
                bus_stop();
            end
        end else if (pick < 65) begin
            bus_start();
            put_byte(dev_byte(1'b0));
            put_address();
            bus_start();
            put_byte(dev_byte(1'b1));
            get_bytes($urandom_range(1, 4));
            bus_stop();
        end else if (pick < 80) begin
            bus_start();
            put_byte(dev_byte(1'b1));
            get_bytes($urandom_range(1, 3));
            bus_stop();
        end else if (pick < 90) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            // odd device byte or an aborted frame
            bus_start();
            put_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                put_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                send_pins(1'b0, 1'($urandom_range(0, 1)));
            bus_stop();
        end
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold the sender until every status word is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        logic        smode [4];
        logic [15:0] blen [4];
        smode = '{1'b1, 1'b0, 1'b0, 1'b1};
        blen  = '{16'd50, 16'd0, 16'hFFFF, 16'($urandom_range(1, 2000))};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        quiet         = 1'b0;
        word_cnt      = 0;
        stamp         = 32'd0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int p = 0; p < 4; p++) begin
            drain();
            small_on = smode[p];
            reg_write(REG_SMALL, {31'd0, smode[p]});
            reg_write(REG_BUSY, {16'd0, blen[p]});
            if (p == 0) begin
                // page write, then a START inside the write cycle
                write_frame(2);
                bus_start();
                put_byte(dev_byte(1'b0));
                bus_stop();
                // read back with the stamp at its extremes
                stamp = 32'hFFFF_FFF0;
                bus_start();
                put_byte(dev_byte(1'b1));
                get_bytes(2);
                bus_stop();
                stamp = 32'd0;
                // odd device byte, then repeated levels
                bus_start();
                put_byte(8'h55);
                send_pins(1'b1, 1'b1);
                send_pins(1'b1, 1'b1);
                stamp = 32'hFFFF_FFFF;
                send_pins(1'b0, 1'b0);
            end
            while (word_cnt < (p + 1) * 165) begin
                quiet = (p == 2);
                random_frame();
            end
            quiet = 1'b0;
        end
        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_front.sv
hw/rtl/i2cee_back.sv
hw/rtl/i2c_serial_eeprom_slave.sv
bench/i2c_serial_eeprom_checker.sv
bench/i2c_serial_eeprom_slave_tb.sv
